FILE: rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// shared constants and types of the indexed min-heap
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int CAPACITY   = 1024;
   localparam int HANDLES    = 1024;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int HND_W      = $clog2(HANDLES);
   localparam int HCNT_W     = $clog2(HANDLES + 1);
   localparam int VAL_W      = 32;

   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_PEEK    = 3'd1;
   localparam logic [2:0] OP_DEL_MIN = 3'd2;
   localparam logic [2:0] OP_DEL_HND = 3'd3;
   localparam logic [2:0] OP_CHANGE  = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_NOLIVE = 2'd3;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [HND_W-1:0] handle;
   } entry_type;

endpackage

FILE: rtl/indexed_min_heap_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// indexed binary min-heap of signed 32-bit values with handle tracking
// ----------------------------------------------------------------------------
// One transaction at a time: a new request is taken only after the previous
// response has been accepted. A delete or change first looks up the handle's
// slot, and a delete then moves the last entry into the freed slot. Sift-down
// waits after each swap, because the second write of the swap needs the single
// write port of the heap memory. At 1024 entries the worst case is a delete by
// handle whose replacement sinks nine levels. Each handle's slot is stored with
// a live bit; handles at or above the next-handle count were never given out,
// so no clearing pass follows reset.
module indexed_min_heap_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_opcode,
   input  logic [imh_pkg::HND_W-1:0]     req_handle,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [31:0]            rsp_min_value,
   output logic [imh_pkg::HND_W-1:0]     rsp_assigned_handle
);
   import imh_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_PEEK  = 4'd2;
   localparam logic [3:0] S_HSLOT = 4'd3;
   localparam logic [3:0] S_RLAST = 4'd4;
   localparam logic [3:0] S_WLAST = 4'd5;
   localparam logic [3:0] S_UPRD  = 4'd6;
   localparam logic [3:0] S_UPCMP = 4'd7;
   localparam logic [3:0] S_DNRD  = 4'd8;
   localparam logic [3:0] S_DNRR  = 4'd9;
   localparam logic [3:0] S_DNCMP = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;
   localparam logic [3:0] S_RCUR  = 4'd12;
   localparam logic [3:0] S_HSW   = 4'd13;

   // memories, handle map carries a live bit on top
   entry_type         heap_mem [CAPACITY];
   logic [SLOT_W:0]   hslot_mem [HANDLES];

   entry_type         heap_rd;
   logic [SLOT_W:0]   hslot_rd;
   logic              hp_we, hs_we;
   logic [SLOT_W-1:0] hp_addr, hp_waddr;
   entry_type         hp_wdata;
   logic [HND_W-1:0]  hs_addr;
   logic [SLOT_W:0]   hs_wdata;

   always_ff @(posedge clock) begin
      if (hp_we) heap_mem[hp_waddr] <= hp_wdata;
      heap_rd <= heap_mem[hp_addr];
   end
   always_ff @(posedge clock) begin
      if (hs_we) hslot_mem[hs_addr] <= hs_wdata;
      hslot_rd <= hslot_mem[hs_addr];
   end

   logic [3:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [HND_W-1:0]  hnd_ff, hnd_in;
   logic [31:0]       val_ff, val_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HCNT_W-1:0] nh_ff, nh_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   entry_type         ent_ff, ent_in;   // entry being sifted
   entry_type         lch_ff, lch_in;
   logic              down_ff, down_in; // skip sift-down after sift-up
   logic [1:0]        sts_ff, sts_in;
   logic [31:0]       min_ff, min_in;
   logic [HND_W-1:0]  asg_ff, asg_in;
   logic              rv_ff, rv_in;
   // second write of a swap pending
   logic              pw_ff, pw_in;
   logic [SLOT_W-1:0] pws_ff, pws_in;
   entry_type         pwe_ff, pwe_in;

   logic [CNT_W:0]    lidx, ridx;
   logic [SLOT_W-1:0] par;
   logic              smaller_l, smaller_r;
   entry_type         best;

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = sts_ff;
   assign rsp_min_value = min_ff;
   assign rsp_assigned_handle = asg_ff;

   assign lidx = {1'b0, cur_ff, 1'b1};
   assign ridx = lidx + 1'b1;
   assign par  = (cur_ff - 1'b1) >> 1;

   always_comb begin
      state_in = state_ff; op_in = op_ff; hnd_in = hnd_ff; val_in = val_ff;
      cnt_in = cnt_ff; nh_in = nh_ff; cur_in = cur_ff; ent_in = ent_ff;
      lch_in = lch_ff; down_in = down_ff; sts_in = sts_ff; min_in = min_ff;
      asg_in = asg_ff; rv_in = rv_ff;
      pw_in = 1'b0; pws_in = pws_ff; pwe_in = pwe_ff;
      hp_we = 1'b0; hp_addr = cur_ff; hp_waddr = cur_ff; hp_wdata = ent_ff;
      hs_we = 1'b0; hs_addr = hnd_ff; hs_wdata = {1'b1, cur_ff};
      smaller_l = 1'b0; smaller_r = 1'b0; best = ent_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      // pending second write of a swap: heap entry and its handle map
      if (pw_ff) begin
         hp_we = 1'b1; hp_waddr = pws_ff; hp_wdata = pwe_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_opcode; hnd_in = req_handle; val_in = req_value;
               sts_in = ST_OK; min_in = '0; asg_in = '0;
               state_in = S_DEC;
            end
            hp_addr = '0;
         end
         S_DEC: begin
            hp_addr = '0;
            case (op_ff)
               OP_INSERT: begin
                  if (cnt_ff >= CNT_W'(CAPACITY) || nh_ff >= HCNT_W'(HANDLES)) begin
                     sts_in = ST_FULL; state_in = S_DONE;
                  end else begin
                     ent_in = '{value: val_ff, handle: nh_ff[HND_W-1:0]};
                     asg_in = nh_ff[HND_W-1:0];
                     cur_in = cnt_ff[SLOT_W-1:0];
                     cnt_in = cnt_ff + 1'b1; nh_in = nh_ff + 1'b1;
                     down_in = 1'b1; // insert: sift-up only
                     state_in = S_UPRD;
                  end
               end
               OP_PEEK: begin
                  if (cnt_ff == '0) begin sts_in = ST_EMPTY; state_in = S_DONE; end
                  else state_in = S_PEEK;
               end
               OP_DEL_MIN: begin
                  if (cnt_ff == '0) begin sts_in = ST_EMPTY; state_in = S_DONE; end
                  else begin cur_in = '0; state_in = S_RCUR; end
               end
               OP_DEL_HND, OP_CHANGE: begin
                  // handles at or above the next handle were never given out
                  if ({1'b0, hnd_ff} >= nh_ff) begin
                     sts_in = ST_NOLIVE; state_in = S_DONE;
                  end else state_in = S_HSLOT;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PEEK: begin
            min_in = heap_rd.value; state_in = S_DONE;
         end
         S_HSLOT: begin
            hs_addr = hnd_ff;
            state_in = S_HSW;
         end
         S_HSW: begin
            if (!hslot_rd[SLOT_W]) begin
               sts_in = ST_NOLIVE; state_in = S_DONE;
            end else begin
               cur_in = hslot_rd[SLOT_W-1:0];
               if (op_ff == OP_CHANGE) begin
                  ent_in = '{value: val_ff, handle: hnd_ff};
                  down_in = 1'b0;
                  state_in = S_UPRD;
               end else state_in = S_RCUR;
            end
         end
         S_RCUR: begin
            // read current slot to learn its handle
            hp_addr = cur_ff; state_in = S_RLAST;
         end
         S_RLAST: begin
            // retire the deleted handle
            hs_we = 1'b1; hs_addr = heap_rd.handle; hs_wdata = {1'b0, cur_ff};
            hp_addr = SLOT_W'(cnt_ff - 1'b1);
            cnt_in = cnt_ff - 1'b1;
            state_in = S_WLAST;
         end
         S_WLAST: begin
            ent_in = heap_rd;
            down_in = 1'b0;
            if (cnt_ff == '0 || cur_ff == cnt_ff[SLOT_W-1:0]) state_in = S_DONE;
            else state_in = S_UPRD;
         end
         S_UPRD: begin
            // read parent
            hp_addr = par;
            if (cur_ff == '0) begin
               hp_we = 1'b1; hp_waddr = cur_ff; hp_wdata = ent_ff;
               hs_we = 1'b1; hs_addr = ent_ff.handle; hs_wdata = {1'b1, cur_ff};
               state_in = down_ff ? S_DONE : S_DNRD;
            end else if (!pw_ff) state_in = S_UPCMP;
         end
         S_UPCMP: begin
            if ($signed(ent_ff.value) < $signed(heap_rd.value)) begin
               // parent moves down into cur
               hp_we = 1'b1; hp_waddr = cur_ff; hp_wdata = heap_rd;
               hs_we = 1'b1; hs_addr = heap_rd.handle; hs_wdata = {1'b1, cur_ff};
               cur_in = par; down_in = 1'b1; // moved up: skip sift-down
               state_in = S_UPRD;
            end else begin
               hp_we = 1'b1; hp_waddr = cur_ff; hp_wdata = ent_ff;
               hs_we = 1'b1; hs_addr = ent_ff.handle; hs_wdata = {1'b1, cur_ff};
               state_in = down_ff ? S_DONE : S_DNRD;
            end
         end
         S_DNRD: begin
            if (!pw_ff) begin
               if (lidx >= (CNT_W+1)'(cnt_ff)) state_in = S_DONE;
               else begin hp_addr = lidx[SLOT_W-1:0]; state_in = S_DNRR; end
            end
         end
         S_DNRR: begin
            lch_in = heap_rd;
            hp_addr = ridx[SLOT_W-1:0];
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            smaller_l = $signed(lch_ff.value) < $signed(ent_ff.value);
            best = smaller_l ? lch_ff : ent_ff;
            smaller_r = (ridx < (CNT_W+1)'(cnt_ff)) &&
                        ($signed(heap_rd.value) < $signed(best.value));
            if (smaller_r || smaller_l) begin
               hp_we = 1'b1; hp_waddr = cur_ff;
               hp_wdata = smaller_r ? heap_rd : lch_ff;
               hs_we = 1'b1; hs_addr = hp_wdata.handle; hs_wdata = {1'b1, cur_ff};
               cur_in = smaller_r ? ridx[SLOT_W-1:0] : lidx[SLOT_W-1:0];
               // place entry at child slot next cycle (overwritten if it sinks)
               pw_in = 1'b1; pws_in = cur_in; pwe_in = ent_ff;
               state_in = S_DNRD;
            end else state_in = S_DONE;
         end
         S_DONE: begin
            if (!pw_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // the handle map of a sunk entry follows its final slot
      if (pw_ff && !hs_we) begin
         hs_we = 1'b1; hs_addr = pwe_ff.handle; hs_wdata = {1'b1, pws_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; nh_ff <= '0; rv_ff <= 1'b0;
         pw_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; nh_ff <= nh_in; rv_ff <= rv_in;
         pw_ff <= pw_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; hnd_ff <= hnd_in; val_ff <= val_in; cur_ff <= cur_in;
      ent_ff <= ent_in; lch_ff <= lch_in; down_ff <= down_in; sts_ff <= sts_in;
      min_ff <= min_in; asg_ff <= asg_in; pws_ff <= pws_in; pwe_ff <= pwe_in;
   end

endmodule
